// ===== hw/rtl/eaq_pkg.sv =====
package eaq_pkg;

  localparam int AngW = 16;
  localparam int QW = 16;
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int RemW = 14;

  localparam logic signed [17:0] AngFull = 18'sd46080;
  localparam logic [RemW-1:0] AngQuarter = 14'd11520;
  localparam logic [27:0] RadPerUnitQ40 = 28'd149922641;
  localparam logic signed [CW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [QW-1:0] QOne = 16'sd16384;

  typedef logic [1:0] quad_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } cs_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h3243F6A8; 1: t = 32'h1DAC6705; 2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6; 4: t = 32'h03FEAB76; 5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA; 7: t = 32'h007FFF55; 8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; default: t = 32'h0000007F;
    endcase
    return $signed({1'b0, t});
  endfunction

endpackage

// ===== hw/rtl/eaq_sincos.sv =====
module eaq_sincos #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [eaq_pkg::AngW-1:0] ang,
  output eaq_pkg::cs_t                 cs
);
  import eaq_pkg::*;

  // Stage 0: reduce the half angle modulo 360 degrees, split off quadrant.
  logic signed [17:0] a_mod;
  logic [16:0] a_pos;
  quad_t quad_nxt;
  logic [RemW-1:0] rem_nxt;
  quad_t q0_r;
  logic [RemW-1:0] rem_r;

  always_comb begin
    a_mod = {{2{ang[AngW-1]}}, ang};
    if (a_mod >= AngFull) begin
      a_mod = a_mod - AngFull;
    end else if (a_mod < 0) begin
      a_mod = a_mod + AngFull;
    end
    a_pos = a_mod[16:0];
    quad_nxt = 2'd0;
    rem_nxt = a_pos[RemW-1:0];
    if (a_pos >= 17'd34560) begin
      quad_nxt = 2'd3;
      rem_nxt = RemW'(a_pos - 17'd34560);
    end else if (a_pos >= 17'd23040) begin
      quad_nxt = 2'd2;
      rem_nxt = RemW'(a_pos - 17'd23040);
    end else if (a_pos >= 17'(AngQuarter)) begin
      quad_nxt = 2'd1;
      rem_nxt = RemW'(a_pos - 17'(AngQuarter));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0_r <= quad_nxt;
      rem_r <= rem_nxt;
    end
  end

  // CORDIC rotation pipeline, one stage per iteration.
  logic signed [CW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_r [CORDIC_STAGES+1];
  quad_t q_r [CORDIC_STAGES+1];

  // Stage 1: remainder to radians Q30, which also loads the CORDIC start vector.
  logic [41:0] prod;
  assign prod = 42'(rem_r) * 42'(RadPerUnitQ40) + 42'd512;
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GainQ30;
      y_r[0] <= '0;
      z_r[0] <= $signed({1'b0, prod[41:10]});
      q_r[0] <= q0_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam int Sh = (i < 24) ? i : 23;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (i >= 24) begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end else if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> Sh);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> Sh);
          z_r[i+1] <= z_r[i] - atan_q30(Sh);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> Sh);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> Sh);
          z_r[i+1] <= z_r[i] + atan_q30(Sh);
        end
      end
    end
  end

  // Quadrant folding.
  logic signed [CW-1:0] xf, yf;
  assign xf = x_r[CORDIC_STAGES];
  assign yf = y_r[CORDIC_STAGES];
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[CORDIC_STAGES])
        2'd0: begin cs.c <= xf;  cs.s <= yf;  end
        2'd1: begin cs.c <= -yf; cs.s <= xf;  end
        2'd2: begin cs.c <= -xf; cs.s <= -yf; end
        default: begin cs.c <= yf; cs.s <= -xf; end
      endcase
    end
  end

endmodule

// ===== hw/rtl/eaq_merge.sv =====
module eaq_merge (
  input  logic                    clk,
  input  logic                    en,
  input  eaq_pkg::cs_t            r,
  input  eaq_pkg::cs_t            p,
  input  eaq_pkg::cs_t            y,
  output logic [4*eaq_pkg::QW-1:0] q
);
  import eaq_pkg::*;

  // Stage A: pairwise roll by pitch products, rounded to Q30.
  logic signed [2*CW-1:0] cc, sc, cs2, ss;
  logic signed [CW-1:0] cc_r, sc_r, cs_r, ss_r, cy_r, sy_r;
  assign cc = r.c * p.c + (68'sd1 <<< 29);
  assign sc = r.s * p.c + (68'sd1 <<< 29);
  assign cs2 = r.c * p.s + (68'sd1 <<< 29);
  assign ss = r.s * p.s + (68'sd1 <<< 29);
  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= CW'(cc >>> 30);
      sc_r <= CW'(sc >>> 30);
      cs_r <= CW'(cs2 >>> 30);
      ss_r <= CW'(ss >>> 30);
      cy_r <= y.c;
      sy_r <= y.s;
    end
  end

  // Stage B: products with the yaw factor, Q60.
  logic signed [2*CW-1:0] t_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= cc_r * cy_r;
      t_r[1] <= ss_r * sy_r;
      t_r[2] <= sc_r * cy_r;
      t_r[3] <= cs_r * sy_r;
      t_r[4] <= cs_r * cy_r;
      t_r[5] <= sc_r * sy_r;
      t_r[6] <= cc_r * sy_r;
      t_r[7] <= ss_r * cy_r;
    end
  end

  // Stage C: sums, rounding to Q14 and clamping.
  function automatic logic [QW-1:0] to_q14(input logic signed [2*CW-1:0] v);
    logic signed [2*CW-1:0] rr;
    rr = (v + (68'sd1 <<< 45)) >>> 46;
    if (rr > 68'sd16384) rr = 68'sd16384;
    if (rr < -68'sd16384) rr = -68'sd16384;
    return rr[QW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q[QW-1:0]      <= to_q14(t_r[0] + t_r[1]);
      q[2*QW-1:QW]   <= to_q14(t_r[2] - t_r[3]);
      q[3*QW-1:2*QW] <= to_q14(t_r[4] + t_r[5]);
      q[4*QW-1:3*QW] <= to_q14(t_r[6] - t_r[7]);
    end
  end

endmodule

// ===== hw/rtl/euler_angles_to_quaternion.sv =====
// Channel | Direction | tdata fields (low bit first)
// in_     | slave     | roll_deg[15:0], pitch_deg[31:16], yaw_deg[47:32]
// out_    | master    | qw[15:0], qx[31:16], qy[47:32], qz[63:48]
//
// One request is taken each cycle while the output is not stalled. The path runs
// through the pipelined CORDIC of each lane, then the product stages.
// The whole pipeline advances only when its last stage is empty or taken,
// so a stall on the output holds every stage in place.
// Reset (rst_n, synchronous, active low) clears the valid bits only.
module euler_angles_to_quaternion #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // roll_deg, pitch_deg, yaw_deg
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // qw, qx, qy, qz
);
  import eaq_pkg::*;

  localparam int Lat = CORDIC_STAGES + 6;

  logic en;
  logic [Lat-1:0] vld_r;
  cs_t cs_rl, cs_pt, cs_yw;

  // The pipeline moves whenever the output slot is free or being taken.
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_tvalid};
    end
  end

  // Three identical lanes, one per Euler angle.
  eaq_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .ang(in_tdata[15:0]), .cs(cs_rl));
  eaq_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .ang(in_tdata[31:16]), .cs(cs_pt));
  eaq_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .ang(in_tdata[47:32]), .cs(cs_yw));

  // The merge stages form the quaternion from the lane results.
  eaq_merge u_merge (
    .clk(clk), .en(en), .r(cs_rl), .p(cs_pt), .y(cs_yw), .q(out_tdata));

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request lost");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import eaq_pkg::*;

  localparam int Stages = 16;
  localparam int Latency = Stages + 6;
  localparam longint Limit = 400000;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [15:0] qw;
  } quat_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [47:0] in_tdata;    // roll_deg, pitch_deg, yaw_deg
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;   // qw, qx, qy, qz

  angles_t pending_angles[$];
  quat_t expected_quats[$];
  int errors = 0;
  longint cycle = 0;
  bit hold_for_drain = 0;
  bit in_fire = 0;
  bit out_fire = 0;

  euler_angles_to_quaternion #(.CORDIC_STAGES(Stages)) dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Handshakes as seen at the rising edge, for use at the following falling edge.
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
  end

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint sra(longint v, int n);
    return v >>> n;
  endfunction

  // Cosine and sine (Q30) of a half angle in units of 1/128 degree.
  function automatic void half_angle_trig(input logic signed [15:0] h,
                                          output longint c, output longint s);
    int a;
    int quad;
    int rem;
    longint x, y, z, nx, ny;
    a = int'(h) % 46080;
    if (a < 0) a += 46080;
    quad = a / 11520;
    rem = a % 11520;
    z = sra(longint'(rem) * 149922641 + 512, 10);
    x = 652032874;
    y = 0;
    for (int i = 0; i < Stages && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i);
        ny = y + sra(x, i);
        z -= longint'(atan_q30(i));
      end else begin
        nx = x + sra(y, i);
        ny = y - sra(x, i);
        z += longint'(atan_q30(i));
      end
      x = nx;
      y = ny;
    end
    // Fold the quadrant back by rotating the first-quadrant result.
    case (quad)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint triple_product(longint a, longint b, longint c);
    return sra(a * b + (longint'(1) << 29), 30) * c;
  endfunction

  function automatic logic signed [15:0] round_to_q14(longint sum);
    longint r;
    r = sra(sum + (longint'(1) << 45), 46);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic quat_t angles_to_quat(angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_angle_trig(a.roll, cr, sr);
    half_angle_trig(a.pitch, cp, sp);
    half_angle_trig(a.yaw, cy, sy);
    q.qw = round_to_q14(triple_product(cr, cp, cy) + triple_product(sr, sp, sy));
    q.qx = round_to_q14(triple_product(sr, cp, cy) - triple_product(cr, sp, sy));
    q.qy = round_to_q14(triple_product(cr, sp, cy) + triple_product(sr, cp, sy));
    q.qz = round_to_q14(triple_product(cr, cp, sy) - triple_product(sr, sp, cy));
    return q;
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);  // any 16-bit pattern, also far outside the nominal range
      1: return 16'($urandom_range(0, 8) * 2880 - 11520);  // multiples of 22.5 degrees
      default: return 16'($urandom_range(0, 46080) - 23040);
    endcase
  endfunction

  // Driver: each request waits a random gap, then holds valid until accepted.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // Request still waiting for acceptance.
    end else begin
      if (in_tvalid) begin
        expected_quats.push_back(angles_to_quat(angles_t'(in_tdata)));
        void'(pending_angles.pop_front());
        send_gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (send_gap > 0 || pending_angles.size() == 0 ||
          (hold_for_drain && expected_quats.size() != 0)) begin
        if (send_gap > 0) send_gap--;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_angles[0];
      end
    end
  end

  // Sink backpressure is also drawn per result, with runs of no stall.
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_fire) begin
      recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      out_tready <= (recv_gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= (recv_gap == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    quat_t got, want;
    cycle++;
    if (rst_n && out_tvalid && out_tready) begin
      got = quat_t'(out_tdata);
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_quats.pop_front();
        if (got.qw !== want.qw) begin
          $display("%0t: qw expected %0d actual %0d", $time, want.qw, got.qw);
          errors++;
        end
        if (got.qx !== want.qx) begin
          $display("%0t: qx expected %0d actual %0d", $time, want.qx, got.qx);
          errors++;
        end
        if (got.qy !== want.qy) begin
          $display("%0t: qy expected %0d actual %0d", $time, want.qy, got.qy);
          errors++;
        end
        if (got.qz !== want.qz) begin
          $display("%0t: qz expected %0d actual %0d", $time, want.qz, got.qz);
          errors++;
        end
      end
    end
    if (cycle > Limit) begin
      $display("** euler_angles_to_quaternion: FAILED **");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] corners[10];
    angles_t a;
    corners = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520,
                16'sd5760, 16'sh7FFF, 16'sh8000, 16'shB400, -16'sd1};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: each lane alone at quadrant edges and one end of the 16-bit range,
    // then all three together, including values far outside the nominal range.
    for (int i = 0; i < 7; i++) begin
      a = '{yaw: 16'sd0, pitch: 16'sd0, roll: corners[i]};
      pending_angles.push_back(a);
    end
    for (int i = 1; i < 10; i += 2) begin
      pending_angles.push_back('{yaw: 16'sd0, pitch: corners[i], roll: 16'sd0});
      pending_angles.push_back('{yaw: corners[i], pitch: 16'sd0, roll: 16'sd0});
    end
    pending_angles.push_back('{yaw: 16'sh7FFF, pitch: 16'sh8000, roll: 16'sh5555});
    pending_angles.push_back('{yaw: 16'shAAAA, pitch: 16'sh7FFF, roll: 16'sh8000});
    pending_angles.push_back('{yaw: 16'sd23040, pitch: 16'sd23040, roll: 16'sd23040});

    // Let the whole directed part drain before the random traffic starts.
    hold_for_drain = 1'b1;
    wait (pending_angles.size() == 0 && expected_quats.size() == 0);
    @(negedge clk);
    hold_for_drain = 1'b0;

    for (int n = 0; n < 1800; n++) begin
      a.roll = rand_angle();
      a.pitch = rand_angle();
      a.yaw = rand_angle();
      pending_angles.push_back(a);
    end

    wait (pending_angles.size() == 0 && !in_tvalid && expected_quats.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("** euler_angles_to_quaternion: PASSED **");
    end else begin
      $display("** euler_angles_to_quaternion: FAILED **");
    end
    $finish;
  end

endmodule
